[rtl/ilt_pkg.sv]
// shared types and constants of the indexed list table
package ilt_pkg;

   // capacity of the list and derived widths
   localparam int DEPTH     = 64;
   localparam int POS_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int INDEX_W   = 7;
   localparam int CMP_W     = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam int WORD_W    = 32;
   localparam int GROUP_N   = 8;
   localparam int GROUP_W   = 3;
   localparam int GROUPS    = (DEPTH + GROUP_N - 1) / GROUP_N;

   // request operations
   typedef enum logic [2:0] {
      MODE_APPEND      = 3'd0,
      MODE_INSERT      = 3'd1,
      MODE_REMOVE_AT   = 3'd2,
      MODE_REMOVE_LAST = 3'd3,
      MODE_READ        = 3'd4,
      MODE_FIND        = 3'd5
   } mode_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_RANGE    = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_FULL     = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_GROUP,
      S_DONE
   } state_type;

   // request beat
   typedef struct packed {
      logic [2:0]         mode;
      logic [6:0]         index;
      logic signed [31:0] value;
   } req_type;

   // result beat
   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] read_value;
      logic [5:0]         found_index;
      logic [6:0]         count;
   } rsp_type;

   // control broadcast to every cell
   typedef struct packed {
      logic                     eval;
      logic                     shift_up;
      logic                     shift_down;
      logic                     find;
      logic                     read;
      logic [CMP_W-1:0]         pos;
      logic [CMP_W-1:0]         index;
      logic [CMP_W-1:0]         count;
      logic signed [WORD_W-1:0] value;
   } cell_ctl_type;

endpackage

[rtl/indexed_list_table_core.sv]
// top level of the indexed list table: sequencer, row of cells and reduction
//
// Holds an ordered list of up to DEPTH signed 32-bit words in a row of cells.
// A request beat (req: mode, index, value) is taken at a clock edge where
// start is high and busy is low. Append, insert, remove at index, remove
// last, read and find are supported; each request gives one result beat.
// The result (rsp: status, read_value, found_index, count) is on the rsp
// port for exactly one cycle while rsp_strobe is high; the receiver cannot
// stall, so it must take the beat in that cycle.
// A request passes the evaluate, group reduce and result states in order.
// busy stays high until the result cycle ends, so a new request is taken
// only after the last result has been given. All cells shift or compare in
// the evaluate cycle; for read and find, the compare flags are registered
// then and the group reduction is registered in the group reduce state.
// Synchronous reset clears the count and the sequencer; the list reads as
// empty right after reset and no clearing pass is needed.
module indexed_list_table_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ilt_pkg::req_type req,
   output logic             rsp_strobe,
   output ilt_pkg::rsp_type rsp
);
   import ilt_pkg::*;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   status_type         status_ff, status_in;
   cell_ctl_type       ctl;

   logic [CMP_W-1:0]   count_ext;
   logic [CMP_W-1:0]   index_ext;
   mode_type           mode;

   logic signed [WORD_W-1:0] cell_word [DEPTH];
   logic [GROUPS*GROUP_N-1:0] pad_match;
   logic signed [WORD_W-1:0] pad_rd    [GROUPS*GROUP_N];
   logic [GROUPS-1:0]        grp_any;
   logic [GROUP_W-1:0]       grp_first [GROUPS];
   logic signed [WORD_W-1:0] grp_rd    [GROUPS];

   logic                     found_any;
   logic [31:0]              found_pos;
   logic signed [WORD_W-1:0] rd_value;
   logic [31:0]              count_wide;

   assign count_ext = CMP_W'(count_ff);
   assign index_ext = CMP_W'(req_ff.index);
   assign mode      = mode_type'(req_ff.mode);

   // sequencer: next state, operation decode and cell control
   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      count_in       = count_ff;
      status_in      = status_ff;
      ctl            = '0;
      ctl.index      = index_ext;
      ctl.count      = count_ext;
      ctl.value      = req_ff.value;
      busy           = (state_ff != S_IDLE);
      rsp_strobe     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            ctl.eval  = 1'b1;
            status_in = ST_OK;
            case (mode)
               MODE_APPEND, MODE_INSERT: begin
                  if (count_ext == CMP_W'(DEPTH)) begin
                     status_in = ST_FULL;
                  end else begin
                     ctl.shift_up = 1'b1;
                     ctl.pos      = ((mode == MODE_APPEND) || (index_ext > count_ext)) ?
                                    count_ext : index_ext;
                     count_in     = count_ff + CNT_W'(1);
                  end
               end
               MODE_REMOVE_AT: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else if (index_ext >= count_ext) begin
                     status_in = ST_RANGE;
                  end else begin
                     ctl.shift_down = 1'b1;
                     ctl.pos        = index_ext;
                     count_in       = count_ff - CNT_W'(1);
                  end
               end
               MODE_REMOVE_LAST: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               MODE_READ: begin
                  ctl.read = 1'b1;
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else if (index_ext >= count_ext) begin
                     status_in = ST_RANGE;
                  end
               end
               MODE_FIND: begin
                  ctl.find = 1'b1;
               end
               default: begin
               end
            endcase
            state_in = S_GROUP;
         end
         S_GROUP: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_strobe = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // request and status holding registers
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      status_ff <= status_in;
   end

   // row of cells, each passing words to its neighbors
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [WORD_W-1:0] left_w, right_w;
      if (g == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_word[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = cell_word[g+1];
      end
      ilt_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cell_pos   (CMP_W'(g)),
         .left_word  (left_w),
         .right_word (right_w),
         .word       (cell_word[g]),
         .match      (pad_match[g]),
         .rd_word    (pad_rd[g])
      );
   end

   // pad the last group with idle slots
   for (genvar g = DEPTH; g < GROUPS * GROUP_N; g++) begin : g_pad
      assign pad_match[g] = 1'b0;
      assign pad_rd[g]    = '0;
   end

   // first reduction level, one unit per eight cells
   for (genvar g = 0; g < GROUPS; g++) begin : g_group
      logic signed [WORD_W-1:0] grp_words [GROUP_N];
      for (genvar k = 0; k < GROUP_N; k++) begin : g_tap
         assign grp_words[k] = pad_rd[g*GROUP_N + k];
      end
      ilt_group u_group (
         .clock    (clock),
         .load     (state_ff == S_GROUP),
         .match    (pad_match[g*GROUP_N +: GROUP_N]),
         .rd_word  (grp_words),
         .any      (grp_any[g]),
         .first    (grp_first[g]),
         .rd_value (grp_rd[g])
      );
   end

   // final level: lowest matching group and merged read word
   always_comb begin
      found_any = |grp_any;
      found_pos = '0;
      rd_value  = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grp_any[g]) begin
            found_pos = 32'(g * GROUP_N) + 32'(grp_first[g]);
         end
      end
      for (int g = 0; g < GROUPS; g++) begin
         rd_value = rd_value | grp_rd[g];
      end
   end

   // result beat
   assign count_wide = 32'(count_ff);
   always_comb begin
      rsp             = '0;
      rsp.count       = count_wide[6:0];
      rsp.read_value  = rd_value;
      if (mode == MODE_FIND) begin
         rsp.status      = found_any ? ST_OK : ST_NOTFOUND;
         rsp.found_index = found_pos[5:0];
      end else begin
         rsp.status      = status_ff;
      end
   end

endmodule

[rtl/ilt_cell.sv]
// one list slot: holds a word, shifts with its neighbors, compares and selects
module ilt_cell (
   input  logic                              clock,
   input  ilt_pkg::cell_ctl_type             ctl,
   input  logic [ilt_pkg::CMP_W-1:0]         cell_pos,
   input  logic signed [ilt_pkg::WORD_W-1:0] left_word,
   input  logic signed [ilt_pkg::WORD_W-1:0] right_word,
   output logic signed [ilt_pkg::WORD_W-1:0] word,
   output logic                              match,
   output logic signed [ilt_pkg::WORD_W-1:0] rd_word
);
   import ilt_pkg::*;

   logic signed [WORD_W-1:0] word_ff, word_in;
   logic                     match_ff, match_in;
   logic signed [WORD_W-1:0] rd_ff, rd_in;
   logic                     live;

   // shift, compare and select from the current contents
   always_comb begin
      live     = (cell_pos < ctl.count);
      word_in  = word_ff;
      if (ctl.shift_up && (cell_pos > ctl.pos)) begin
         word_in = left_word;
      end else if (ctl.shift_up && (cell_pos == ctl.pos)) begin
         word_in = ctl.value;
      end else if (ctl.shift_down && (cell_pos >= ctl.pos)) begin
         word_in = right_word;
      end
      match_in = ctl.find && live && (word_ff == ctl.value);
      rd_in    = (ctl.read && live && (cell_pos == ctl.index)) ? word_ff : '0;
   end

   // slot and flag registers, loaded in the evaluate cycle
   always_ff @(posedge clock) begin
      if (ctl.eval) begin
         word_ff  <= word_in;
         match_ff <= match_in;
         rd_ff    <= rd_in;
      end
   end

   assign word    = word_ff;
   assign match   = match_ff;
   assign rd_word = rd_ff;

endmodule

[rtl/ilt_group.sv]
// registered reduction over eight cells: first match and selected word
module ilt_group (
   input  logic                              clock,
   input  logic                              load,
   input  logic [ilt_pkg::GROUP_N-1:0]       match,
   input  logic signed [ilt_pkg::WORD_W-1:0] rd_word [ilt_pkg::GROUP_N],
   output logic                              any,
   output logic [ilt_pkg::GROUP_W-1:0]       first,
   output logic signed [ilt_pkg::WORD_W-1:0] rd_value
);
   import ilt_pkg::*;

   logic                     any_ff, any_in;
   logic [GROUP_W-1:0]       first_ff, first_in;
   logic signed [WORD_W-1:0] rd_ff, rd_in;

   // lowest matching slot and or of the selected words
   always_comb begin
      any_in   = |match;
      first_in = '0;
      rd_in    = '0;
      for (int i = GROUP_N - 1; i >= 0; i--) begin
         if (match[i]) begin
            first_in = GROUP_W'(i);
         end
      end
      for (int i = 0; i < GROUP_N; i++) begin
         rd_in = rd_in | rd_word[i];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         any_ff   <= any_in;
         first_ff <= first_in;
         rd_ff    <= rd_in;
      end
   end

   assign any      = any_ff;
   assign first    = first_ff;
   assign rd_value = rd_ff;

endmodule

[dv/indexed_list_table_checker.sv]
// checker for the indexed list table: models the list, predicts each result beat and compares
module indexed_list_table_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  ilt_pkg::req_type req,
   input  logic             rsp_strobe,
   input  ilt_pkg::rsp_type rsp,
   output int               failures,
   output int               outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   import ilt_pkg::*;

   // shadow copy of the list
   logic signed [31:0] list_words [DEPTH];
   int                 held;

   // results predicted but not yet seen
   rsp_type            outcome_q [$];

   initial begin
      failures    = 0;
      outstanding = 0;
      held        = 0;
   end

   // one line per mismatch, counted
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      failures++;
   endtask

   // apply one request to the shadow list and form its result
   task automatic apply_list_op(input req_type r, output rsp_type o);
      status_type         st;
      logic signed [31:0] rd;
      int                 fi;
      int                 pos;
      st = ST_OK;
      rd = '0;
      fi = 0;
      case (r.mode)
         MODE_APPEND, MODE_INSERT: begin
            if (held >= DEPTH) begin
               st = ST_FULL;
            end else begin
               // an insert past the end lands at the end
               pos = (r.mode == MODE_APPEND || r.index > held) ? held : r.index;
               for (int k = held; k > pos; k--) list_words[k] = list_words[k-1];
               list_words[pos] = r.value;
               held++;
            end
         end
         MODE_REMOVE_AT: begin
            if (held == 0) st = ST_EMPTY;
            else if (r.index >= held) st = ST_RANGE;
            else begin
               for (int k = r.index; k + 1 < held; k++) list_words[k] = list_words[k+1];
               held--;
            end
         end
         MODE_REMOVE_LAST: begin
            if (held == 0) st = ST_EMPTY;
            else held--;
         end
         MODE_READ: begin
            if (held == 0) st = ST_EMPTY;
            else if (r.index >= held) st = ST_RANGE;
            else rd = list_words[r.index];
         end
         MODE_FIND: begin
            // first match wins
            st = ST_NOTFOUND;
            for (int k = 0; k < held; k++) begin
               if (st == ST_NOTFOUND && list_words[k] == r.value) begin
                  st = ST_OK;
                  fi = k;
               end
            end
         end
         default: begin
            // spare modes do nothing
         end
      endcase
      o.status      = st;
      o.read_value  = rd;
      o.found_index = fi[5:0];
      o.count       = held[6:0];
   endtask

   // compare result beats first, then predict the request beat taken at this edge
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         held = 0;
         outcome_q.delete();
      end else begin
         if (rsp_strobe) begin
            if (outcome_q.size() == 0) begin
               report_mismatch("result beat with none expected", '0, '0);
            end else begin
               want = outcome_q.pop_front();
               if (rsp.status !== want.status)
                  report_mismatch("status", 32'(rsp.status), 32'(want.status));
               if (rsp.read_value !== want.read_value)
                  report_mismatch("read_value", rsp.read_value, want.read_value);
               if (rsp.found_index !== want.found_index)
                  report_mismatch("found_index", 32'(rsp.found_index),
                                  32'(want.found_index));
               if (rsp.count !== want.count)
                  report_mismatch("count", 32'(rsp.count), 32'(want.count));
            end
         end
         if (start && !busy) begin
            apply_list_op(req, want);
            outcome_q.push_back(want);
         end
      end
      outstanding <= outcome_q.size();
   end

endmodule

[dv/indexed_list_table_core_test.sv]
// testbench top for the indexed list table: stimulus, watchdog and verdict
module indexed_list_table_core_test;

   timeunit 1ns;
   timeprecision 1ps;

   import ilt_pkg::*;

   localparam int          RANDOM_ITEMS  = 1250;
   localparam int          IDLE_LIMIT    = 400;
   localparam int          DRAIN_CYCLES  = 8;
   localparam logic [2:0]  MODE_SPARE_6  = 3'd6;
   localparam logic [2:0]  MODE_SPARE_7  = 3'd7;

   // traffic mix of one stretch of random requests
   typedef enum int {
      PHASE_GROW,
      PHASE_MIX,
      PHASE_SHRINK
   } phase_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_beat;
   logic    rsp_strobe;
   rsp_type rsp_beat;
   int      failures;
   int      outstanding;
   int      idle_cycles;
   int      burst_left;
   logic [6:0]  seen_count;
   logic [31:0] key_pool [8];

   indexed_list_table_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req        (req_beat),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_beat)
   );

   indexed_list_table_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req         (req_beat),
      .rsp_strobe  (rsp_strobe),
      .rsp         (rsp_beat),
      .failures    (failures),
      .outstanding (outstanding)
   );

   // clock
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // last count reported, used only to steer indexes
   always @(posedge clock) begin
      if (reset) seen_count <= '0;
      else if (rsp_strobe) seen_count <= rsp_beat.count;
   end

   // watchdog on cycles with no beat in either direction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // present one request beat, hold until taken, then maybe pause
   task automatic issue(input logic [2:0] mode, input logic [6:0] index,
                        input logic [31:0] value);
      req_beat <= '{mode, index, value};
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
   endtask

   function automatic logic [2:0] pick_mode(input phase_type ph);
      int roll;
      roll = $urandom_range(0, 99);
      case (ph)
         PHASE_GROW: begin
            if (roll < 45)      return MODE_APPEND;
            else if (roll < 85) return MODE_INSERT;
            else if (roll < 90) return MODE_REMOVE_AT;
            else if (roll < 93) return MODE_REMOVE_LAST;
            else if (roll < 96) return MODE_READ;
            else                return MODE_FIND;
         end
         PHASE_SHRINK: begin
            if (roll < 40)      return MODE_REMOVE_AT;
            else if (roll < 70) return MODE_REMOVE_LAST;
            else if (roll < 78) return MODE_APPEND;
            else if (roll < 84) return MODE_INSERT;
            else if (roll < 92) return MODE_READ;
            else                return MODE_FIND;
         end
         default: begin
            if (roll < 4)       return ($urandom_range(0, 1) != 0) ? MODE_SPARE_6 : MODE_SPARE_7;
            else if (roll < 20) return MODE_APPEND;
            else if (roll < 35) return MODE_INSERT;
            else if (roll < 50) return MODE_REMOVE_AT;
            else if (roll < 60) return MODE_REMOVE_LAST;
            else if (roll < 80) return MODE_READ;
            else                return MODE_FIND;
         end
      endcase
   endfunction

   // mostly near the live range, sometimes anywhere
   function automatic logic [6:0] pick_index();
      if ($urandom_range(0, 3) != 0) return 7'($urandom_range(0, seen_count));
      return 7'($urandom_range(0, 127));
   endfunction

   // repeated keys so finds hit
   function automatic logic [31:0] pick_value();
      if ($urandom_range(0, 1) != 0) return key_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   initial begin : stimulus
      int        done_items;
      int        stretch;
      int        episode;
      phase_type ph;

      start      = 1'b0;
      req_beat   = '0;
      reset      = 1'b1;
      burst_left = $urandom_range(1, 30);
      key_pool   = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     $urandom, $urandom, $urandom, $urandom};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty list: every failing case plus the spare modes
      issue(MODE_REMOVE_AT,   7'd0,   32'h0);
      issue(MODE_REMOVE_LAST, 7'd0,   32'h0);
      issue(MODE_READ,        7'd0,   32'h0);
      issue(MODE_FIND,        7'd0,   32'h0);
      issue(MODE_SPARE_6,     7'd127, 32'hFFFF_FFFF);
      issue(MODE_SPARE_7,     7'd127, 32'hFFFF_FFFF);
      // build a short list from the extremes
      issue(MODE_APPEND,      7'd0,   32'h7FFF_FFFF);
      issue(MODE_APPEND,      7'd127, 32'h8000_0000);
      issue(MODE_INSERT,      7'd0,   32'hFFFF_FFFF);
      // insert beyond the count falls back to append
      issue(MODE_INSERT,      7'd127, 32'h0);
      issue(MODE_INSERT,      7'd2,   32'h5555_5555);
      issue(MODE_INSERT,      7'd5,   32'hAAAA_AAAA);
      // reads inside and past the end
      issue(MODE_READ,        7'd0,   32'h0);
      issue(MODE_READ,        7'd5,   32'h0);
      issue(MODE_READ,        7'd6,   32'h0);
      issue(MODE_READ,        7'd127, 32'h0);
      // find hit and miss
      issue(MODE_FIND,        7'd0,   32'h8000_0000);
      issue(MODE_FIND,        7'd127, 32'h0);
      issue(MODE_FIND,        7'd0,   32'h0001_2345);
      // removes: out of range, head, the slot before the tail, last
      issue(MODE_REMOVE_AT,   7'd6,   32'h0);
      issue(MODE_REMOVE_AT,   7'd0,   32'h0);
      issue(MODE_REMOVE_AT,   7'd3,   32'h0);
      issue(MODE_REMOVE_LAST, 7'd0,   32'h0);
      issue(MODE_FIND,        7'd0,   32'hFFFF_FFFF);

      // random stretches that grow toward capacity and shrink toward empty
      done_items = 0;
      episode    = 0;
      while (done_items < RANDOM_ITEMS) begin
         case (episode % 4)
            0:       ph = PHASE_GROW;
            2:       ph = PHASE_SHRINK;
            default: ph = PHASE_MIX;
         endcase
         stretch = (ph == PHASE_MIX) ? $urandom_range(20, 60) : $urandom_range(70, 120);
         repeat (stretch) begin
            issue(pick_mode(ph), pick_index(), pick_value());
            done_items++;
         end
         episode++;
      end
      start <= 1'b0;

      // drain and give the verdict
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
